// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define FSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// checked on every clock edge, reset included
`define FSC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/fsc_pkg.sv =====
// types, constants and plane derivation for the frustum sphere classifier
package fsc_pkg;

    localparam int PLANE_COUNT  = 6;
    localparam int NUM_REGS     = 8;
    localparam int IDX_W        = $clog2(NUM_REGS);
    localparam int FLIGHT_W     = $clog2(PLANE_COUNT + 1);
    localparam int SERIAL_STEPS = 67;

    typedef logic [NUM_REGS-1:0][63:0] mat_t;

    typedef logic [1:0] cls_t;
    localparam cls_t CLS_INSIDE  = 2'd0;
    localparam cls_t CLS_ISECT   = 2'd1;
    localparam cls_t CLS_OUTSIDE = 2'd2;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [30:0]        r;
        cls_t               cls;
    } item_t;

    typedef struct packed {
        logic signed [32:0] a;
        logic signed [32:0] b;
        logic signed [32:0] c;
        logic signed [32:0] d;
    } plane_t;

    // matrix element k, column-major, two elements per register
    function automatic logic signed [31:0] elem(mat_t m, int k);
        logic [63:0] w;
        w = m[(k >> 1) & (NUM_REGS - 1)];
        return (k & 1) != 0 ? w[63:32] : w[31:0];
    endfunction

    // row paired with the fourth row: near/far, bottom/top, left/right
    function automatic int row_sel(int p);
        int k;
        unique case (p)
            0, 1:    k = 2;
            2, 3:    k = 1;
            default: k = 0;
        endcase
        return k;
    endfunction

    function automatic plane_t plane_coef(mat_t m, int p);
        logic signed [32:0] co [4];
        logic signed [32:0] base;
        logic signed [32:0] other;
        plane_t pl;
        for (int j = 0; j < 4; j++) begin
            base  = 33'(elem(m, j * 4 + 3));
            other = 33'(elem(m, j * 4 + row_sel(p)));
            co[j] = (p & 1) != 0 ? base - other : base + other;
        end
        pl.a = co[0];
        pl.b = co[1];
        pl.c = co[2];
        pl.d = co[3];
        return pl;
    endfunction

endpackage

// ===== hw/rtl/fsc_plane_cell.sv =====
// one plane test cell: multiply steps, bit-serial squaring and multiply, compare
module fsc_plane_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  fsc_pkg::plane_t plane,
    input  logic            in_valid,
    output logic            in_ready,
    input  fsc_pkg::item_t  in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output fsc_pkg::item_t  out_item
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SER  = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [2:0] STEP_AX  = 3'd0;
    localparam logic [2:0] STEP_BY  = 3'd1;
    localparam logic [2:0] STEP_CZ  = 3'd2;
    localparam logic [2:0] STEP_AA  = 3'd3;
    localparam logic [2:0] STEP_BB  = 3'd4;
    localparam logic [2:0] STEP_CC  = 3'd5;
    localparam logic [2:0] STEP_RR  = 3'd6;
    localparam logic [2:0] STEP_END = 3'd7;

    function automatic logic [32:0] mag33(logic [32:0] v);
        return v[32] ? (~v + 33'd1) : v;
    endfunction

    logic [2:0]          state_reg, state_next;
    logic [2:0]          step_reg, step_next;
    fsc_pkg::item_t      item_reg, item_next;
    logic [65:0]         prod_reg, prod_next;
    logic                prod_neg_reg, prod_neg_next;
    logic                prod_vld_reg, prod_vld_next;
    logic [2:0]          prod_step_reg, prod_step_next;
    logic signed [67:0]  num_reg, num_next;
    logic [66:0]         sum_reg, sum_next;
    logic [66:0]         nmag_reg, nmag_next;
    logic [133:0]        nsh_reg, nsh_next;
    logic [133:0]        n2_reg, n2_next;
    logic [61:0]         r2m_reg, r2m_next;
    logic [133:0]        ssh_reg, ssh_next;
    logic [133:0]        rs_reg, rs_next;
    logic [6:0]          cnt_reg, cnt_next;
    logic                nneg_reg, nneg_next;

    logic [32:0]         op_a, op_b;
    logic                op_neg;
    logic [65:0]         mul_full;
    logic signed [67:0]  term;
    logic signed [67:0]  num_abs;

    // operand select per multiply step
    always_comb begin
        op_a   = '0;
        op_b   = '0;
        op_neg = 1'b0;
        unique case (step_reg)
            STEP_AX: begin
                op_a   = mag33(plane.a);
                op_b   = mag33(33'(item_reg.x));
                op_neg = plane.a[32] ^ item_reg.x[31];
            end
            STEP_BY: begin
                op_a   = mag33(plane.b);
                op_b   = mag33(33'(item_reg.y));
                op_neg = plane.b[32] ^ item_reg.y[31];
            end
            STEP_CZ: begin
                op_a   = mag33(plane.c);
                op_b   = mag33(33'(item_reg.z));
                op_neg = plane.c[32] ^ item_reg.z[31];
            end
            STEP_AA: begin
                op_a = mag33(plane.a);
                op_b = mag33(plane.a);
            end
            STEP_BB: begin
                op_a = mag33(plane.b);
                op_b = mag33(plane.b);
            end
            STEP_CC: begin
                op_a = mag33(plane.c);
                op_b = mag33(plane.c);
            end
            STEP_RR: begin
                op_a = {2'b00, item_reg.r};
                op_b = {2'b00, item_reg.r};
            end
            default: begin
                op_a = '0;
            end
        endcase
    end

    assign mul_full = op_a * op_b;
    assign term     = $signed({2'b00, prod_reg});
    assign num_abs  = num_reg[67] ? -num_reg : num_reg;

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        item_next      = item_reg;
        prod_next      = prod_reg;
        prod_neg_next  = prod_neg_reg;
        prod_vld_next  = prod_vld_reg;
        prod_step_next = prod_step_reg;
        num_next       = num_reg;
        sum_next       = sum_reg;
        nmag_next      = nmag_reg;
        nsh_next       = nsh_reg;
        n2_next        = n2_reg;
        r2m_next       = r2m_reg;
        ssh_next       = ssh_reg;
        rs_next        = rs_reg;
        cnt_next       = cnt_reg;
        nneg_next      = nneg_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    item_next = in_item;
                    if (in_item.cls == fsc_pkg::CLS_OUTSIDE) begin
                        state_next = ST_DONE;
                    end else begin
                        num_next      = {{19{plane.d[32]}}, plane.d, 16'h0000};
                        sum_next      = '0;
                        step_next     = STEP_AX;
                        prod_vld_next = 1'b0;
                        state_next    = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                if (step_reg != STEP_END) begin
                    prod_next      = mul_full;
                    prod_neg_next  = op_neg;
                    prod_step_next = step_reg;
                    prod_vld_next  = 1'b1;
                    step_next      = step_reg + 3'd1;
                end
                if (prod_vld_reg) begin
                    if (prod_step_reg <= STEP_CZ) begin
                        num_next = prod_neg_reg ? num_reg - term : num_reg + term;
                    end else if (prod_step_reg <= STEP_CC) begin
                        sum_next = sum_reg + {1'b0, prod_reg};
                    end
                end
                // product register holds the squared radius here
                if (step_reg == STEP_END) begin
                    nmag_next  = num_abs[66:0];
                    nsh_next   = {67'd0, num_abs[66:0]};
                    n2_next    = '0;
                    r2m_next   = prod_reg[61:0];
                    ssh_next   = {67'd0, sum_reg};
                    rs_next    = '0;
                    cnt_next   = '0;
                    nneg_next  = num_reg[67];
                    state_next = ST_SER;
                end
            end
            ST_SER: begin
                if (nmag_reg[0]) n2_next = n2_reg + nsh_reg;
                if (r2m_reg[0])  rs_next = rs_reg + ssh_reg;
                nmag_next = nmag_reg >> 1;
                nsh_next  = nsh_reg << 1;
                r2m_next  = r2m_reg >> 1;
                ssh_next  = ssh_reg << 1;
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg == 7'(fsc_pkg::SERIAL_STEPS - 1)) state_next = ST_CMP;
            end
            ST_CMP: begin
                // zero-length normal: plane skipped
                if (sum_reg != '0) begin
                    if (nneg_reg) begin
                        item_next.cls = (n2_reg > rs_reg) ? fsc_pkg::CLS_OUTSIDE
                                                          : fsc_pkg::CLS_ISECT;
                    end else if (n2_reg < rs_reg) begin
                        item_next.cls = fsc_pkg::CLS_ISECT;
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_ready) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= STEP_AX;
            prod_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            prod_vld_reg <= prod_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        prod_reg      <= prod_next;
        prod_neg_reg  <= prod_neg_next;
        prod_step_reg <= prod_step_next;
        num_reg       <= num_next;
        sum_reg       <= sum_next;
        nmag_reg      <= nmag_next;
        nsh_reg       <= nsh_next;
        n2_reg        <= n2_next;
        r2m_reg       <= r2m_next;
        ssh_reg       <= ssh_next;
        rs_reg        <= rs_next;
        cnt_reg       <= cnt_next;
        nneg_reg      <= nneg_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign out_item  = item_reg;

endmodule

// ===== hw/rtl/frustum_sphere_cull.sv =====
// top level: classifies a bounding sphere against a view frustum
// usage
// - s_ channel takes one sphere per item: centre x, y, z in q16.16, radius in q15.16
// - m_ channel returns one classification per item: 0 inside, 1 intersects,
//   2 outside, in the order the spheres came in
// - cfg channel writes the 4x4 projection-view matrix, column-major, two
//   elements per register; write it only while no item is in flight
// - planes (near, far, bottom, top, left, right) come from the matrix rows
//   with plain adds and subtracts, one plane per cell of a six-cell chain
// work and flow
// - each cell: multiply steps, 67 squaring steps, a compare and a handoff,
//   one plane after another along the chain
// - up to six items are in the chain at once, one per cell; a new item is
//   taken as soon as the first cell has handed its last item on
// - once a plane finds the sphere outside, the later cells skip their
//   tests and pass it straight on
// reset: all cells go idle, in-flight items are dropped, matrix is identity
// stall: the last cell holds its result until m_tready; earlier cells keep
//   working and stall only when their successor is still busy
`include "assert_macros.svh"

module frustum_sphere_cull (
    input  logic                        aclk,
    input  logic                        aresetn,
    // centre_x [31:0], centre_y [63:32], centre_z [95:64], sphere_radius [126:96]
    input  logic [127:0]                s_tdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // classification [1:0]
    output logic [7:0]                  m_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [fsc_pkg::IDX_W-1:0]   cfg_index,
    input  logic [63:0]                 cfg_data
);

    localparam int N = fsc_pkg::PLANE_COUNT;

    fsc_pkg::mat_t mat_reg, mat_next;

    // matrix registers, identity after reset
    always_comb begin
        mat_next = mat_reg;
        if (cfg_valid && cfg_ready) mat_next[cfg_index] = cfg_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat_reg <= {64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
                        64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000};
        end else begin
            mat_reg <= mat_next;
        end
    end

    assign cfg_ready = 1'b1;

    // chain links: link 0 is the input, link N the output
    logic            link_vld [N+1];
    logic            link_rdy [N+1];
    fsc_pkg::item_t  link_item [N+1];

    always_comb begin
        link_item[0].x   = $signed(s_tdata[31:0]);
        link_item[0].y   = $signed(s_tdata[63:32]);
        link_item[0].z   = $signed(s_tdata[95:64]);
        link_item[0].r   = s_tdata[126:96];
        link_item[0].cls = fsc_pkg::CLS_INSIDE;
    end

    assign link_vld[0] = s_tvalid;
    assign s_tready    = link_rdy[0];

    for (genvar g = 0; g < N; g++) begin : g_cell
        fsc_pkg::plane_t plane;
        assign plane = fsc_pkg::plane_coef(mat_reg, g);

        fsc_plane_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .plane     (plane),
            .in_valid  (link_vld[g]),
            .in_ready  (link_rdy[g]),
            .in_item   (link_item[g]),
            .out_valid (link_vld[g+1]),
            .out_ready (link_rdy[g+1]),
            .out_item  (link_item[g+1])
        );
    end

    assign m_tvalid    = link_vld[N];
    assign link_rdy[N] = m_tready;
    assign m_tdata     = {6'd0, link_item[N].cls};

    // items taken but not yet delivered
    logic [fsc_pkg::FLIGHT_W-1:0] flight_reg, flight_next;

    always_comb begin
        flight_next = flight_reg;
        if (s_tvalid && s_tready && !(m_tvalid && m_tready)) begin
            flight_next = flight_reg + 1'b1;
        end else if (!(s_tvalid && s_tready) && m_tvalid && m_tready) begin
            flight_next = flight_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flight_reg <= '0;
        end else begin
            flight_reg <= flight_next;
        end
    end

    `FSC_ASSERT(a_cls_code, m_tvalid |-> (m_tdata[1:0] != 2'd3) && (m_tdata[7:2] == 6'd0), "bad classification code")
    `FSC_ASSERT(a_flight_cap, flight_reg <= fsc_pkg::FLIGHT_W'(N), "more items in flight than cells")
    `FSC_ASSERT(a_out_has_item, m_tvalid |-> (flight_reg != '0), "result with no item in flight")
    `FSC_ASSERT_RST(a_reset_idle, !aresetn |=> !m_tvalid && (flight_reg == '0), "chain not idle after reset")

endmodule
